>>> rtl/fts_pkg.sv
`default_nettype none

package fts_pkg;

  localparam int DELTA_W   = 24;
  localparam int PERIOD_W  = 16;
  localparam int SCALE_W   = 11;
  localparam int CATCH_W   = 20;
  localparam int LIMIT_W   = 20;
  localparam int ACC_W     = 32;
  localparam int TOTAL_W   = 48;
  localparam int COUNT_W   = 32;
  localparam int RUN_W     = 9;
  localparam int ALPHA_W   = 16;
  localparam int PEND_W    = 10;
  localparam int SCALE_FRAC = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CATCH_UP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG_LIMIT = 3'd4;

  localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD   = 16'd8333;
  localparam logic [SCALE_W-1:0]  RST_TIME_SCALE    = 11'd256;
  localparam logic [CATCH_W-1:0]  RST_CATCH_UP      = 20'd100000;
  localparam logic [LIMIT_W-1:0]  RST_BACKLOG_LIMIT = 20'd100000;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ADD   = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_SUB   = 8'b0001_0000,
    S_CHK   = 8'b0010_0000,
    S_ALPHA = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    DIV_HOLD,
    DIV_ACC,
    DIV_BUDGET,
    DIV_TRIM,
    DIV_ALPHA
  } div_op_t;

  typedef enum logic {
    MUL_SCALE,
    MUL_STEPS
  } mul_op_t;

endpackage

`default_nettype wire

>>> rtl/fts_if.sv
`default_nettype none

interface fts_in_if;
  import fts_pkg::*;

  logic               valid;
  logic               ready;
  logic [DELTA_W-1:0] frame_delta_us;
  logic               allow_sim;
  logic               step_request;

  modport source (output valid, output frame_delta_us, output allow_sim,
                  output step_request, input ready);
  modport sink (input valid, input frame_delta_us, input allow_sim,
                input step_request, output ready);
endinterface

interface fts_out_if;
  import fts_pkg::*;

  logic               valid;
  logic               ready;
  logic [RUN_W-1:0]   steps_run;
  logic               overloaded;
  logic [ALPHA_W-1:0] alpha_q16;
  logic [PEND_W-1:0]  pending_steps;
  logic [COUNT_W-1:0] overload_frames;
  logic [TOTAL_W-1:0] dropped_time_us;
  logic [TOTAL_W-1:0] clamped_time_us;
  logic [TOTAL_W-1:0] total_steps;
  logic [ACC_W-1:0]   peak_backlog_us;

  modport source (output valid, output steps_run, output overloaded, output alpha_q16,
                  output pending_steps, output overload_frames, output dropped_time_us,
                  output clamped_time_us, output total_steps, output peak_backlog_us,
                  input ready);
  modport sink (input valid, input steps_run, input overloaded, input alpha_q16,
                input pending_steps, input overload_frames, input dropped_time_us,
                input clamped_time_us, input total_steps, input peak_backlog_us,
                output ready);
endinterface

`default_nettype wire

>>> rtl/fixed_timestep_scheduler.sv
// Fixed-timestep scheduler. Each transfer on in_ch carries one frame delta in
// microseconds together with the allow and single-step flags of that frame.
// For every input transfer exactly one result transfer leaves on out_ch with
// the step count, overload flag, interpolation alpha, queued steps and the
// running totals. Registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce. Indexes past the last register are
// ignored. One frame is worked on at a time. A single-step frame goes
// straight to the result; a held frame runs the divider on the accumulator
// and then for the alpha; a running frame runs the scale multiply, the
// accumulator and budget divisions, the step multiply, the trim division
// when the backlog is over the limit, and the alpha division. The next input
// transfer can follow in the cycle after the result is loaded. The shared
// restoring divider retires one quotient bit per cycle and runs up to four
// times per frame; the shift-add multiplier takes one scale or step bit a cycle.
// The result sits in an output register, so the next frame is accepted while
// it waits; if the receiver still stalls when the next result is ready, the
// block holds that result and takes no new input.
// A synchronous reset loads the register defaults and clears the accumulator,
// the pending single step and all running totals.
`default_nettype none

module fixed_timestep_scheduler #(
  parameter int MAX_STEPS_PER_FRAME = 256,
  parameter int FRAME_CLAMP_US      = 100000
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  fts_in_if.sink                               in_ch,
  fts_out_if.source                            out_ch
);
  import fts_pkg::*;

  localparam int STEP_W  = $clog2(MAX_STEPS_PER_FRAME + 1);
  localparam int MB_W    = (STEP_W > SCALE_W) ? STEP_W : SCALE_W;
  localparam int PROD_W  = DELTA_W + MB_W;
  localparam int MCNT_W  = $clog2(MB_W + 1);
  localparam int DIV_W   = ACC_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int BUD_W   = CATCH_W + 1;
  localparam logic [DELTA_W-1:0] CLAMP     = DELTA_W'(FRAME_CLAMP_US);
  localparam logic [ACC_W-1:0]   MAX_STEPS = ACC_W'(MAX_STEPS_PER_FRAME);

  logic [PERIOD_W-1:0] step_period_r;
  logic [SCALE_W-1:0]  time_scale_r;
  logic                paused_r;
  logic [CATCH_W-1:0]  catch_up_r;
  logic [LIMIT_W-1:0]  limit_r;

  state_t              state_r;
  logic [ACC_W-1:0]    acc_r;
  logic                pending_r;
  logic [TOTAL_W-1:0]  dropped_r;
  logic [TOTAL_W-1:0]  clamped_r;
  logic [TOTAL_W-1:0]  step_total_r;
  logic [ACC_W-1:0]    peak_r;
  logic [COUNT_W-1:0]  overload_cnt_r;

  logic [PERIOD_W-1:0] per_r;
  logic                over_r;
  logic [STEP_W-1:0]   steps_r;
  logic [ACC_W-1:0]    n_r;
  logic [ACC_W-1:0]    pend_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [ALPHA_W-1:0]  alpha_r;

  mul_op_t             mul_op_r;
  logic [PROD_W-1:0]   mul_a0_r;
  logic [PROD_W-1:0]   mul_a1_r;
  logic [MB_W-1:0]     mul_b_r;
  logic [PROD_W-1:0]   prod0_r;
  logic [PROD_W-1:0]   prod1_r;
  logic [MCNT_W-1:0]   mul_cnt_r;

  div_op_t             div_op_r;
  logic [DIV_W-1:0]    div_dvd_r;
  logic [DIV_W-1:0]    div_q_r;
  logic [PERIOD_W-1:0] div_rem_r;
  logic [DCNT_W-1:0]   div_cnt_r;

  logic                out_valid_r;
  logic [RUN_W-1:0]    out_steps_r;
  logic                out_over_r;
  logic [ALPHA_W-1:0]  out_alpha_r;
  logic [PEND_W-1:0]   out_pend_r;
  logic [COUNT_W-1:0]  out_ovf_r;
  logic [TOTAL_W-1:0]  out_drop_r;
  logic [TOTAL_W-1:0]  out_clamp_r;
  logic [TOTAL_W-1:0]  out_total_r;
  logic [ACC_W-1:0]    out_peak_r;

  logic [PERIOD_W-1:0] per_now;
  logic                held;
  logic                clamp_hit;
  logic [PERIOD_W:0]   div_shift;
  logic                div_ge;
  logic [PERIOD_W:0]   div_diff;
  logic [ACC_W:0]      acc_sum;
  logic [ACC_W-1:0]    acc_sat;
  logic [BUD_W-1:0]    bud_num;
  logic [ACC_W-1:0]    bud_cl;
  logic [ACC_W-1:0]    steps_sel;
  logic [LIMIT_W-1:0]  allowed_whole;
  logic [LIMIT_W-1:0]  allowed;
  logic [TOTAL_W-1:0]  step_total_nxt;
  logic [ACC_W-1:0]    steps_wide;
  logic                fin_load;

  assign per_now   = (step_period_r == '0) ? PERIOD_W'(1) : step_period_r;
  assign held      = !in_ch.allow_sim || paused_r || (time_scale_r == '0);
  assign clamp_hit = in_ch.frame_delta_us > CLAMP;

  assign div_shift = {div_rem_r, div_dvd_r[DIV_W-1]};
  assign div_ge    = div_shift >= {1'b0, per_r};
  assign div_diff  = div_shift - {1'b0, per_r};

  assign acc_sum = {1'b0, acc_r} + (ACC_W+1)'(prod1_r[PROD_W-1:SCALE_FRAC]);
  assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

  assign bud_num   = BUD_W'(catch_up_r) + BUD_W'(per_r) - BUD_W'(1);
  assign bud_cl    = (div_q_r == '0) ? ACC_W'(1) :
                     (div_q_r > MAX_STEPS) ? MAX_STEPS : div_q_r;
  assign steps_sel = (n_r < bud_cl) ? n_r : bud_cl;

  assign allowed_whole = (limit_r > LIMIT_W'(rem_r)) ? limit_r - LIMIT_W'(rem_r) : '0;
  assign allowed       = allowed_whole - LIMIT_W'(div_rem_r);

  assign step_total_nxt = step_total_r + TOTAL_W'(steps_r);
  assign steps_wide     = ACC_W'(steps_r);
  assign fin_load       = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r  <= RST_STEP_PERIOD;
      time_scale_r   <= RST_TIME_SCALE;
      paused_r       <= 1'b0;
      catch_up_r     <= RST_CATCH_UP;
      limit_r        <= RST_BACKLOG_LIMIT;
      state_r        <= S_IDLE;
      acc_r          <= '0;
      pending_r      <= 1'b0;
      dropped_r      <= '0;
      clamped_r      <= '0;
      step_total_r   <= '0;
      peak_r         <= '0;
      overload_cnt_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_PERIOD:   step_period_r <= cfg_wdata[PERIOD_W-1:0];
          CFG_TIME_SCALE:    time_scale_r  <= cfg_wdata[SCALE_W-1:0];
          CFG_PAUSED:        paused_r      <= cfg_wdata[0];
          CFG_CATCH_UP:      catch_up_r    <= cfg_wdata[CATCH_W-1:0];
          CFG_BACKLOG_LIMIT: limit_r       <= cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            per_r <= per_now;
            if (in_ch.allow_sim && (pending_r || in_ch.step_request)) begin
              pending_r <= 1'b0;
              acc_r     <= '0;
              steps_r   <= STEP_W'(1);
              over_r    <= 1'b0;
              alpha_r   <= '0;
              pend_r    <= '0;
              state_r   <= S_FIN;
            end else begin
              pending_r <= pending_r | in_ch.step_request;
              steps_r   <= '0;
              pend_r    <= '0;
              if (held) begin
                over_r    <= 1'b0;
                div_op_r  <= DIV_HOLD;
                div_dvd_r <= acc_r;
                div_q_r   <= '0;
                div_rem_r <= '0;
                div_cnt_r <= DCNT_W'(DIV_W);
                state_r   <= S_DIV;
              end else begin
                over_r    <= clamp_hit;
                mul_op_r  <= MUL_SCALE;
                mul_a0_r  <= clamp_hit ? PROD_W'(in_ch.frame_delta_us - CLAMP) : '0;
                mul_a1_r  <= clamp_hit ? PROD_W'(CLAMP) : PROD_W'(in_ch.frame_delta_us);
                mul_b_r   <= MB_W'(time_scale_r);
                prod0_r   <= '0;
                prod1_r   <= '0;
                mul_cnt_r <= MCNT_W'(MB_W);
                state_r   <= S_MUL;
              end
            end
          end
        end

        S_MUL: begin
          if (mul_cnt_r != '0) begin
            if (mul_b_r[0]) begin
              prod0_r <= prod0_r + mul_a0_r;
              prod1_r <= prod1_r + mul_a1_r;
            end
            mul_a0_r  <= mul_a0_r << 1;
            mul_a1_r  <= mul_a1_r << 1;
            mul_b_r   <= mul_b_r >> 1;
            mul_cnt_r <= mul_cnt_r - MCNT_W'(1);
          end else begin
            unique case (mul_op_r)
              MUL_SCALE: state_r <= S_ADD;
              MUL_STEPS: state_r <= S_SUB;
            endcase
          end
        end

        S_ADD: begin
          if (over_r) begin
            clamped_r <= clamped_r + TOTAL_W'(prod0_r[PROD_W-1:SCALE_FRAC]);
          end
          acc_r <= acc_sat;
          if (acc_sat > peak_r) begin
            peak_r <= acc_sat;
          end
          div_op_r  <= DIV_ACC;
          div_dvd_r <= acc_sat;
          div_q_r   <= '0;
          div_rem_r <= '0;
          div_cnt_r <= DCNT_W'(DIV_W);
          state_r   <= S_DIV;
        end

        S_DIV: begin
          if (div_cnt_r != '0) begin
            div_rem_r <= div_ge ? div_diff[PERIOD_W-1:0] : div_shift[PERIOD_W-1:0];
            div_q_r   <= {div_q_r[DIV_W-2:0], div_ge};
            div_dvd_r <= div_dvd_r << 1;
            div_cnt_r <= div_cnt_r - DCNT_W'(1);
          end else begin
            unique case (div_op_r)
              DIV_HOLD: begin
                rem_r     <= div_rem_r;
                dropped_r <= dropped_r + TOTAL_W'(acc_r - ACC_W'(div_rem_r));
                acc_r     <= ACC_W'(div_rem_r);
                state_r   <= S_ALPHA;
              end
              DIV_ACC: begin
                n_r       <= div_q_r;
                rem_r     <= div_rem_r;
                div_op_r  <= DIV_BUDGET;
                div_dvd_r <= DIV_W'(bud_num) << (DIV_W - BUD_W);
                div_q_r   <= '0;
                div_rem_r <= '0;
                div_cnt_r <= DCNT_W'(BUD_W);
              end
              DIV_BUDGET: begin
                steps_r   <= STEP_W'(steps_sel);
                mul_op_r  <= MUL_STEPS;
                mul_a0_r  <= PROD_W'(per_r);
                mul_b_r   <= MB_W'(steps_sel);
                prod0_r   <= '0;
                mul_cnt_r <= MCNT_W'(MB_W);
                state_r   <= S_MUL;
              end
              DIV_TRIM: begin
                dropped_r <= dropped_r +
                             TOTAL_W'(acc_r - ACC_W'(rem_r) - ACC_W'(allowed));
                acc_r     <= ACC_W'(allowed) + ACC_W'(rem_r);
                pend_r    <= div_q_r;
                state_r   <= S_ALPHA;
              end
              DIV_ALPHA: begin
                alpha_r <= div_q_r[ALPHA_W-1:0];
                state_r <= S_FIN;
              end
              default: state_r <= S_FIN;
            endcase
          end
        end

        S_SUB: begin
          acc_r  <= acc_r - prod0_r[ACC_W-1:0];
          pend_r <= n_r - steps_wide;
          if (n_r > steps_wide) begin
            over_r <= 1'b1;
          end
          state_r <= S_CHK;
        end

        S_CHK: begin
          if (over_r) begin
            overload_cnt_r <= overload_cnt_r + COUNT_W'(1);
          end
          if ((n_r > steps_wide) && (acc_r > ACC_W'(limit_r))) begin
            div_op_r  <= DIV_TRIM;
            div_dvd_r <= DIV_W'(allowed_whole) << (DIV_W - LIMIT_W);
            div_q_r   <= '0;
            div_rem_r <= '0;
            div_cnt_r <= DCNT_W'(LIMIT_W);
            state_r   <= S_DIV;
          end else begin
            state_r <= S_ALPHA;
          end
        end

        S_ALPHA: begin
          div_op_r  <= DIV_ALPHA;
          div_dvd_r <= DIV_W'({rem_r, ALPHA_W'(0)});
          div_q_r   <= '0;
          div_rem_r <= '0;
          div_cnt_r <= DCNT_W'(DIV_W);
          state_r   <= S_DIV;
        end

        S_FIN: begin
          if (fin_load) begin
            step_total_r <= step_total_nxt;
            out_steps_r  <= steps_wide[RUN_W-1:0];
            out_over_r   <= over_r;
            out_alpha_r  <= alpha_r;
            out_pend_r   <= (pend_r > ACC_W'({PEND_W{1'b1}})) ? '1 : pend_r[PEND_W-1:0];
            out_ovf_r    <= overload_cnt_r;
            out_drop_r   <= dropped_r;
            out_clamp_r  <= clamped_r;
            out_total_r  <= step_total_nxt;
            out_peak_r   <= peak_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.steps_run       = out_steps_r;
  assign out_ch.overloaded      = out_over_r;
  assign out_ch.alpha_q16       = out_alpha_r;
  assign out_ch.pending_steps   = out_pend_r;
  assign out_ch.overload_frames = out_ovf_r;
  assign out_ch.dropped_time_us = out_drop_r;
  assign out_ch.clamped_time_us = out_clamp_r;
  assign out_ch.total_steps     = out_total_r;
  assign out_ch.peak_backlog_us = out_peak_r;

  // The fraction handed to the alpha division must already be below one step.
  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALPHA) |-> (rem_r < per_r))
    else $error("fraction not below step period");

  // After the steps are taken, a whole step is left exactly when the budget cut in.
  a_queued_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> ((acc_r >= ACC_W'(per_r)) == (n_r > steps_wide)))
    else $error("queued step check disagrees with quotient");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("input transfer did not start work");

  a_total_tracks_steps: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |=> (step_total_r == $past(step_total_r + TOTAL_W'(steps_r))))
    else $error("step total not advanced by steps run");

endmodule

`default_nettype wire
